// ===== sv/i4dq_pkg.sv =====
`default_nettype none
package i4dq_pkg;
   localparam int unsigned NibbleWidth = 4;
   localparam int unsigned Bf16Width = 16;
   localparam int unsigned ProdWidth = 12;
   localparam logic [15:0] Bf16DefaultNan = 16'hFFC0;
   localparam logic [15:0] Bf16Inf = 16'h7F80;
   localparam logic [15:0] Bf16QuietBit = 16'h0040;

   // decoded operand class of one lane
   typedef enum logic [1:0] {
      KIND_FINITE = 2'd0,
      KIND_NAN    = 2'd1,
      KIND_INF    = 2'd2,
      KIND_DNAN   = 2'd3
   } kind_type;

   // stage 1 -> stage 2 lane record: magnitude product and exponent
   typedef struct packed {
      kind_type kind;
      logic sign;
      logic [15:0] special;
      logic [ProdWidth-1:0] prod;
      logic [7:0] expo;
   } lane_mul_type;

   // stage 2 -> stage 3 lane record: normalized fields before rounding
   typedef struct packed {
      kind_type kind;
      logic sign;
      logic [15:0] special;
      logic zero;
      logic subn;
      logic [6:0] subn_mant;
      logic [3:0] len;
      logic [9:0] bexp;
      logic [ProdWidth-1:0] prod;
   } lane_norm_type;
endpackage
`default_nettype wire

// ===== sv/i4dq_mul.sv =====
`default_nettype none
// Stage 1 logic: difference, decode, small multiply.
module i4dq_mul (
   input  wire logic [3:0] nibble,
   input  wire logic [3:0] zero,
   input  wire logic [15:0] scale,
   output i4dq_pkg::lane_mul_type lane
);
   logic signed [4:0] diff;
   logic [3:0] mag;
   logic [7:0] ex;
   logic [6:0] mant;
   logic [7:0] sig;
   always_comb begin
      diff = $signed({1'b0, nibble}) - $signed({1'b0, zero});
      mag = diff[4] ? 4'(-diff) : diff[3:0];
      ex = scale[14:7];
      mant = scale[6:0];
      sig = (ex == 8'd0) ? {1'b0, mant} : {1'b1, mant};
      lane.sign = scale[15] ^ diff[4];
      lane.prod = {4'd0, sig} * {8'd0, mag};
      lane.expo = (ex == 8'd0) ? 8'd1 : ex;
      lane.special = 16'd0;
      lane.kind = i4dq_pkg::KIND_FINITE;
      if (ex == 8'hFF) begin
         if (mant != 7'd0) begin
            lane.kind = i4dq_pkg::KIND_NAN;
            lane.special = scale | i4dq_pkg::Bf16QuietBit;
         end else if (mag == 4'd0) begin
            lane.kind = i4dq_pkg::KIND_DNAN;
            lane.special = i4dq_pkg::Bf16DefaultNan;
         end else begin
            lane.kind = i4dq_pkg::KIND_INF;
            lane.special = {lane.sign, i4dq_pkg::Bf16Inf[14:0]};
         end
      end
   end
endmodule
`default_nettype wire

// ===== sv/i4dq_norm.sv =====
`default_nettype none
// Stage 2 logic: leading one, exponent, subnormal path.
module i4dq_norm (
   input  wire i4dq_pkg::lane_mul_type lane_in,
   output i4dq_pkg::lane_norm_type lane
);
   logic [3:0] len;
   logic signed [9:0] b;
   logic [18:0] sh;
   always_comb begin
      len = 4'd0;
      for (int i = 0; i < 12; i++) begin
         if (lane_in.prod[i]) len = 4'(i + 1);
      end
      b = $signed({6'd0, len}) + $signed({2'd0, lane_in.expo}) - 10'sd8;
      sh = 19'(lane_in.prod) << 3'(lane_in.expo - 8'd1);
      lane.kind = lane_in.kind;
      lane.sign = lane_in.sign;
      lane.special = lane_in.special;
      lane.zero = (lane_in.prod == '0);
      lane.subn = (b < 10'sd1);
      lane.subn_mant = sh[6:0];
      lane.len = len;
      lane.bexp = b;
      lane.prod = lane_in.prod;
   end
endmodule
`default_nettype wire

// ===== sv/i4dq_round.sv =====
`default_nettype none
// Stage 3 logic: nearest-even rounding and packing.
module i4dq_round (
   input  wire i4dq_pkg::lane_norm_type lane,
   output logic [15:0] result
);
   logic [3:0] sh;
   logic [11:0] q;
   logic [11:0] rem;
   logic [11:0] half;
   logic [9:0] b;
   always_comb begin
      b = lane.bexp;
      q = '0;
      rem = '0;
      half = '0;
      sh = '0;
      if (lane.len <= 4'd8) begin
         q = lane.prod << (4'd8 - lane.len);
      end else begin
         sh = lane.len - 4'd8;
         rem = lane.prod & ((12'd1 << sh) - 12'd1);
         half = 12'd1 << (sh - 4'd1);
         q = lane.prod >> sh;
         if (rem > half || (rem == half && q[0])) q = q + 12'd1;
         if (q == 12'h100) begin
            q = 12'h080;
            b = b + 10'd1;
         end
      end
      case (lane.kind)
         i4dq_pkg::KIND_FINITE: begin
            if (lane.zero) result = {lane.sign, 15'd0};
            else if (lane.subn) result = {lane.sign, 8'd0, lane.subn_mant};
            else if ($signed(b) >= 10'sd255) result = {lane.sign, i4dq_pkg::Bf16Inf[14:0]};
            else result = {lane.sign, b[7:0], q[6:0]};
         end
         default: result = lane.special;
      endcase
   end
endmodule
`default_nettype wire

// ===== sv/int4_group_dequant_bf16_unit.sv =====
`default_nettype none
// Path: a req_ transaction accepted into the multiply register moves on through the
// normalize and round registers, and rsp_valid rises once it reaches the round register.
// Throughput: one transaction per cycle unless rsp_stall backs up the pipeline; three register
// stages (multiply, normalize, round) each hold one transaction and advance independently.
// Reset: synchronous active-high reset clears all stage valid bits;
// payload registers are not reset.
module int4_group_dequant_bf16_unit (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic [7:0] req_packed_byte,
   input  wire logic [3:0] req_zero_first,
   input  wire logic [3:0] req_zero_second,
   input  wire logic [15:0] req_scale_first,
   input  wire logic [15:0] req_scale_second,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [15:0] rsp_weight_first,
   output logic [15:0] rsp_weight_second
);
   i4dq_pkg::lane_mul_type m0_in, m1_in, m0_ff, m1_ff;
   i4dq_pkg::lane_norm_type n0_in, n1_in, n0_ff, n1_ff;
   logic [15:0] w0_in, w1_in, w0_ff, w1_ff;
   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;

   // Each stage advances when its output slot is empty or moving on.
   assign adv3 = !v3_ff || !rsp_stall;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_stall = !adv1;

   i4dq_mul u_mul0 (.nibble(req_packed_byte[3:0]), .zero(req_zero_first),
      .scale(req_scale_first), .lane(m0_in));
   i4dq_mul u_mul1 (.nibble(req_packed_byte[7:4]), .zero(req_zero_second),
      .scale(req_scale_second), .lane(m1_in));
   i4dq_norm u_norm0 (.lane_in(m0_ff), .lane(n0_in));
   i4dq_norm u_norm1 (.lane_in(m1_ff), .lane(n1_in));
   i4dq_round u_rnd0 (.lane(n0_ff), .result(w0_in));
   i4dq_round u_rnd1 (.lane(n1_ff), .result(w1_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   // Payload stages: load only on advance, hold otherwise.
   always_ff @(posedge clock) begin
      if (adv1) begin
         m0_ff <= m0_in;
         m1_ff <= m1_in;
      end
      if (adv2) begin
         n0_ff <= n0_in;
         n1_ff <= n1_in;
      end
      if (adv3) begin
         w0_ff <= w0_in;
         w1_ff <= w1_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_weight_first = w0_ff;
   assign rsp_weight_second = w1_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight_first))
      else $error("result dropped under stall");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff)
      else $error("stall with empty stage");
   a_move: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !rsp_stall |=> rsp_valid)
      else $error("stage two item lost");
endmodule
`default_nettype wire
